// File: rtl/core/aiger_binary_gate_decoder_core_defines.svh
// Assertion macros for the AIGER gate decoder core.
// Used by the top level only; bodies are empty when SYNTHESIS is defined.
`ifndef AIGER_BINARY_GATE_DECODER_CORE_DEFINES_SVH
`define AIGER_BINARY_GATE_DECODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define AGD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("agd assertion failed");
`define AGD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("agd assertion failed");
`else
`define AGD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define AGD_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/core/agd_pkg.sv
// Shared types and constants for the AIGER binary AND-gate decoder.
// No dependencies.
`default_nettype none

package agd_pkg;

    localparam int LITERAL_BITS_DEF = 32;
    localparam int VAR_W            = 31;
    localparam int CFG_ADDR_W       = 1;
    localparam int BYTE_POS_W       = 3;
    localparam int SHIFT_W          = 5;
    localparam int MAX_LEAD_BYTES   = 4;
    localparam int DIGIT_BITS       = 7;
    localparam int TDATA_W          = 96;
    localparam int TUSER_W          = 2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FIRST_GATE_VAR = 1'b0,
        REG_GATE_TOTAL     = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_DELTA_BIG  = 2'd1,
        ST_TOO_LONG   = 2'd2
    } gate_status_t;

    typedef struct packed {
        logic [VAR_W-1:0] gate_var;
        logic [VAR_W-1:0] left_var;
        logic             left_invert;
        logic [VAR_W-1:0] right_var;
        logic             right_invert;
        gate_status_t     status;
        logic             last_gate;
    } gate_rec_t;

    typedef struct packed {
        logic main_valid;
        logic skid_valid;
    } buf_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/aiger_binary_gate_decoder_core.sv
// Each gate record is registered, in the skid entry when the output stalls.
// Throughput: one byte per cycle; a stalled output is absorbed by a
// single skid entry, so s_tready drops only when both output slots are full.
// Reset (aresetn, synchronous, active low): first gate variable 1, gate
// count 0, decode state and output buffer cleared.
// Depends on agd_pkg, agd_step, agd_skid and the core defines header.
`default_nettype none
`include "aiger_binary_gate_decoder_core_defines.svh"

module aiger_binary_gate_decoder_core import agd_pkg::*; #(
    parameter int LITERAL_BITS = LITERAL_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [VAR_W-1:0]      cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] byte_in
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [30:0] gate_var, [61:31] left_var, [62] left_invert,
    // [93:63] right_var, [94] right_invert, [95] zero pad
    output logic [TDATA_W-1:0]         m_tdata,
    output logic [TUSER_W-1:0]         m_tuser,   // [1:0] status
    output logic                       m_tlast    // last_gate
);

    logic      in_xfer;
    logic      rec_valid;
    gate_rec_t rec;
    gate_rec_t out_rec;
    buf_stat_t stat;

    assign in_xfer = s_tvalid && s_tready;

    agd_step #(
        .LITERAL_BITS(LITERAL_BITS)
    ) u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .byte_valid(in_xfer),
        .byte_in   (s_tdata),
        .rec_valid (rec_valid),
        .rec       (rec)
    );

    agd_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rec_valid),
        .push_rec  (rec),
        .can_accept(s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rec   (out_rec),
        .stat      (stat)
    );

    assign m_tdata = {1'b0, out_rec.right_invert, out_rec.right_var,
                      out_rec.left_invert, out_rec.left_var, out_rec.gate_var};
    assign m_tuser = out_rec.status;
    assign m_tlast = out_rec.last_gate;

    `AGD_ASSERT_IMP(a_skid_implies_main, aclk, aresetn, stat.skid_valid, stat.main_valid)
    `AGD_ASSERT_IMP(a_stall_only_when_full, aclk, aresetn, !s_tready, m_tvalid && !m_tready || stat.skid_valid)
    `AGD_ASSERT_IMP(a_bad_rec_zero, aclk, aresetn, m_tvalid && (out_rec.status != ST_OK), out_rec.left_var == '0 && out_rec.right_var == '0 && !out_rec.left_invert && !out_rec.right_invert)
    `AGD_ASSERT_NXT(a_full_pop_keeps_valid, aclk, aresetn, stat.skid_valid && m_tready, m_tvalid && !stat.skid_valid)

endmodule

`default_nettype wire

// File: rtl/core/agd_step.sv
// Per-byte decode: delta accumulation, literal subtract and record build.
// Depends on agd_pkg.
`default_nettype none

module agd_step import agd_pkg::*; #(
    parameter int LITERAL_BITS = LITERAL_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [VAR_W-1:0]      cfg_wdata,
    input  wire logic                  byte_valid,
    input  wire logic [7:0]            byte_in,
    output logic                       rec_valid,
    output gate_rec_t                  rec
);

    localparam int LB = LITERAL_BITS;

    logic [VAR_W-1:0]      current_var_reg, current_var_next;
    logic [VAR_W-1:0]      gate_total_reg, gate_total_next;
    logic [VAR_W-1:0]      gates_done_reg, gates_done_next;
    logic                  phase_reg, phase_next;
    logic [LB-1:0]         delta_accum_reg, delta_accum_next;
    logic [BYTE_POS_W-1:0] byte_pos_reg, byte_pos_next;
    logic [LB-1:0]         left_lit_reg, left_lit_next;
    logic                  first_bad_reg, first_bad_next;

    logic                  active;
    logic                  more;
    logic [SHIFT_W-1:0]    shift;
    logic [LB-1:0]         acc;
    logic [LB-1:0]         base;
    logic [LB-1:0]         minuend;
    logic [LB:0]           diff;
    logic                  too_big;
    logic                  emit;
    gate_status_t          status;

    always_comb begin
        unique case (byte_pos_reg)
            3'd0:    shift = SHIFT_W'(0);
            3'd1:    shift = SHIFT_W'(DIGIT_BITS);
            3'd2:    shift = SHIFT_W'(2 * DIGIT_BITS);
            3'd3:    shift = SHIFT_W'(3 * DIGIT_BITS);
            3'd4:    shift = SHIFT_W'(4 * DIGIT_BITS);
            default: shift = SHIFT_W'(0);
        endcase
    end

    assign active  = gates_done_reg < gate_total_reg;
    assign more    = byte_in[7];
    assign acc     = delta_accum_reg | (LB'(byte_in[6:0]) << shift);
    assign base    = LB'({current_var_reg, 1'b0});
    assign minuend = phase_reg ? left_lit_reg : base;
    assign diff    = {1'b0, minuend} - {1'b0, acc};
    assign too_big = diff[LB];

    always_comb begin
        current_var_next = current_var_reg;
        gate_total_next  = gate_total_reg;
        gates_done_next  = gates_done_reg;
        phase_next       = phase_reg;
        delta_accum_next = delta_accum_reg;
        byte_pos_next    = byte_pos_reg;
        left_lit_next    = left_lit_reg;
        first_bad_next   = first_bad_reg;
        emit             = 1'b0;
        status           = ST_OK;

        if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_FIRST_GATE_VAR: begin
                    current_var_next = cfg_wdata;
                    gates_done_next  = '0;
                    phase_next       = 1'b0;
                    delta_accum_next = '0;
                    byte_pos_next    = '0;
                    left_lit_next    = '0;
                    first_bad_next   = 1'b0;
                end
                REG_GATE_TOTAL: gate_total_next = cfg_wdata;
                default: ;
            endcase
        end else if (byte_valid && active) begin
            if (more) begin
                if (byte_pos_reg >= BYTE_POS_W'(MAX_LEAD_BYTES)) begin
                    emit   = 1'b1;
                    status = ST_TOO_LONG;
                end else begin
                    delta_accum_next = acc;
                    byte_pos_next    = byte_pos_reg + 1'b1;
                end
            end else begin
                delta_accum_next = '0;
                byte_pos_next    = '0;
                if (!phase_reg) begin
                    phase_next     = 1'b1;
                    first_bad_next = too_big;
                    left_lit_next  = too_big ? '0 : diff[LB-1:0];
                end else begin
                    emit   = 1'b1;
                    status = (first_bad_reg || too_big) ? ST_DELTA_BIG : ST_OK;
                end
            end
            if (emit) begin
                current_var_next = current_var_reg + 1'b1;
                gates_done_next  = gates_done_reg + 1'b1;
                phase_next       = 1'b0;
                delta_accum_next = '0;
                byte_pos_next    = '0;
                left_lit_next    = '0;
                first_bad_next   = 1'b0;
            end
        end
    end

    always_comb begin
        rec_valid        = emit;
        rec.gate_var     = current_var_reg;
        rec.status       = status;
        rec.last_gate    = (gates_done_reg + 1'b1) == gate_total_reg;
        rec.left_var     = '0;
        rec.left_invert  = 1'b0;
        rec.right_var    = '0;
        rec.right_invert = 1'b0;
        if (status == ST_OK) begin
            rec.left_var     = VAR_W'(left_lit_reg >> 1);
            rec.left_invert  = left_lit_reg[0];
            rec.right_var    = VAR_W'(diff[LB-1:1]);
            rec.right_invert = diff[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            current_var_reg <= VAR_W'(1);
            gate_total_reg  <= '0;
            gates_done_reg  <= '0;
            phase_reg       <= 1'b0;
            delta_accum_reg <= '0;
            byte_pos_reg    <= '0;
            left_lit_reg    <= '0;
            first_bad_reg   <= 1'b0;
        end else begin
            current_var_reg <= current_var_next;
            gate_total_reg  <= gate_total_next;
            gates_done_reg  <= gates_done_next;
            phase_reg       <= phase_next;
            delta_accum_reg <= delta_accum_next;
            byte_pos_reg    <= byte_pos_next;
            left_lit_reg    <= left_lit_next;
            first_bad_reg   <= first_bad_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/agd_skid.sv
// Output register plus one skid entry for gate records.
// Depends on agd_pkg.
`default_nettype none

module agd_skid import agd_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire gate_rec_t  push_rec,
    output logic            can_accept,
    output logic            out_valid,
    input  wire logic       out_ready,
    output gate_rec_t       out_rec,
    output buf_stat_t       stat
);

    logic      main_valid_reg, main_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    gate_rec_t main_rec_reg, main_rec_next;
    gate_rec_t skid_rec_reg, skid_rec_next;
    logic      pop;

    assign pop = main_valid_reg && out_ready;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_rec_next   = main_rec_reg;
        skid_rec_next   = skid_rec_reg;
        if (skid_valid_reg) begin
            // upstream is held off while the skid entry is full
            if (pop) begin
                main_rec_next   = skid_rec_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_rec_next   = push_rec;
                main_valid_next = 1'b1;
            end else begin
                skid_rec_next   = push_rec;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_rec_reg <= main_rec_next;
        skid_rec_reg <= skid_rec_next;
    end

    assign can_accept      = !skid_valid_reg;
    assign out_valid       = main_valid_reg;
    assign out_rec         = main_rec_reg;
    assign stat.main_valid = main_valid_reg;
    assign stat.skid_valid = skid_valid_reg;

endmodule

`default_nettype wire

// File: sim/aiger_binary_gate_decoder_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for aiger_binary_gate_decoder_core: streams bytes of
// binary AND-gate sections, predicts each gate record and checks every transfer.
// Depends on agd_pkg and the core RTL.

module aiger_binary_gate_decoder_core_tb import agd_pkg::*; ();

    class gate_decode_scoreboard;
        logic [VAR_W-1:0]      first_var;
        logic [VAR_W-1:0]      gate_total;
        logic [VAR_W-1:0]      cur_var;
        logic [VAR_W-1:0]      gates_done;
        logic [31:0]           delta_acc;
        logic [31:0]           left_lit;
        logic [BYTE_POS_W-1:0] byte_pos;
        bit                    second_delta;
        bit                    first_bad;
        gate_rec_t             pending_gates[$];
        int                    errors;

        function new();
            first_var  = 1;
            gate_total = 0;
            errors     = 0;
            restart();
        endfunction

        function void restart();
            cur_var      = first_var;
            gates_done   = '0;
            delta_acc    = '0;
            left_lit     = '0;
            byte_pos     = '0;
            second_delta = 0;
            first_bad    = 0;
        endfunction

        function void write_reg(cfg_reg_t r, logic [VAR_W-1:0] v);
            case (r)
                REG_FIRST_GATE_VAR: begin
                    first_var = v;
                    restart();
                end
                REG_GATE_TOTAL: gate_total = v;
                default: ;
            endcase
        endfunction

        function void push_gate(gate_status_t st, logic [31:0] right);
            gate_rec_t rec;
            rec = '0;
            rec.gate_var = cur_var;
            // bad records carry no input literals
            if (st == ST_OK) begin
                rec.left_var     = left_lit[31:1];
                rec.left_invert  = left_lit[0];
                rec.right_var    = right[31:1];
                rec.right_invert = right[0];
            end
            rec.status    = st;
            rec.last_gate = (VAR_W'(gates_done + 1) == gate_total);
            pending_gates = {pending_gates, rec};
            cur_var      = cur_var + 1'b1;
            gates_done   = gates_done + 1'b1;
            second_delta = 0;
            first_bad    = 0;
            left_lit     = '0;
            delta_acc    = '0;
            byte_pos     = '0;
        endfunction

        // Returns 1 when the byte is consumed, 0 once the section is complete.
        function bit decode_byte(logic [7:0] b);
            logic [63:0] part;
            logic [31:0] delta;
            logic [31:0] base;
            if (gates_done >= gate_total)
                return 0;
            if (b[7]) begin
                if (byte_pos >= MAX_LEAD_BYTES) begin
                    push_gate(ST_TOO_LONG, '0);
                    return 1;
                end
                part      = 64'(b[6:0]) << (DIGIT_BITS * byte_pos);
                delta_acc = delta_acc | part[31:0];
                byte_pos  = byte_pos + 1'b1;
                return 1;
            end
            // high bits of a wide fifth byte fall off here
            part      = 64'(b) << (DIGIT_BITS * byte_pos);
            delta     = delta_acc | part[31:0];
            delta_acc = '0;
            byte_pos  = '0;
            if (!second_delta) begin
                base = {cur_var, 1'b0};
                if (delta > base) begin
                    first_bad = 1;
                    left_lit  = '0;
                end else begin
                    first_bad = 0;
                    left_lit  = base - delta;
                end
                second_delta = 1;
                return 1;
            end
            if (first_bad || delta > left_lit)
                push_gate(ST_DELTA_BIG, '0);
            else
                push_gate(ST_OK, left_lit - delta);
            return 1;
        endfunction

        function void compare_field(string name, logic [VAR_W-1:0] want,
                                    logic [VAR_W-1:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_record(logic [TDATA_W-1:0] tdata, logic [TUSER_W-1:0] tuser,
                                   logic tlast);
            gate_rec_t want;
            if (pending_gates.size() == 0) begin
                $display("%0t: unexpected gate record, expected none, actual tdata %h",
                         $time, tdata);
                errors++;
                return;
            end
            want = pending_gates.pop_front();
            compare_field("gate_var", want.gate_var, tdata[30:0]);
            compare_field("left_var", want.left_var, tdata[61:31]);
            compare_field("left_invert", want.left_invert, tdata[62]);
            compare_field("right_var", want.right_var, tdata[93:63]);
            compare_field("right_invert", want.right_invert, tdata[94]);
            compare_field("status", want.status, tuser);
            compare_field("last_gate", want.last_gate, tlast);
        endfunction
    endclass

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    cfg_reg_t            cfg_addr  = REG_FIRST_GATE_VAR;
    logic [VAR_W-1:0]    cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic [TUSER_W-1:0]  m_tuser;
    logic                m_tlast;

    gate_decode_scoreboard sb;
    logic [7:0]            byte_q[$];
    int                    tx_idle_pct = 0;
    int                    rx_idle_pct = 0;
    int                    used_bytes  = 0;
    bit                    rx_hold_req = 0;

    aiger_binary_gate_decoder_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic send_bytes();
        logic [7:0] b;
        while (byte_q.size() > 0) begin
            b = byte_q.pop_front();
            while ($urandom_range(99) < tx_idle_pct) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= b;
            do @(posedge aclk); while (!s_tready);
            if (sb.decode_byte(b))
                used_bytes++;
        end
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (sb.pending_gates.size() > 0)
            @(posedge aclk);
        // a half-decoded gate may still be in flight
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_cfg(cfg_reg_t r, logic [VAR_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_addr  <= r;
        cfg_wdata <= v;
        @(posedge aclk);
        sb.write_reg(r, v);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic void add_byte(logic [7:0] b);
        byte_q = {byte_q, b};
    endfunction

    // 7-bit little-endian groups; pad adds redundant zero groups
    function automatic void push_num(logic [31:0] v, int pad);
        int n;
        n = 0;
        while (v > 127) begin
            add_byte({1'b1, v[6:0]});
            v = v >> 7;
            n++;
        end
        while (pad > 0 && n < MAX_LEAD_BYTES) begin
            add_byte({1'b1, v[6:0]});
            v = '0;
            n++;
            pad--;
        end
        add_byte({1'b0, v[6:0]});
    endfunction

    function automatic logic [31:0] pick_upto(logic [31:0] lim);
        case ($urandom_range(3))
            0: return $urandom_range(lim < 127 ? lim : 127, 0);
            1: return $urandom_range(lim < 20000 ? lim : 20000, 0);
            2: return $urandom_range(lim, 0);
            default: return $urandom_range(1) ? lim : 32'd0;
        endcase
    endfunction

    function automatic void queue_gate();
        logic [31:0] base;
        logic [31:0] d0;
        logic [31:0] left;
        int          kind;
        int          pad;
        base = {sb.cur_var, 1'b0};
        kind = $urandom_range(99);
        pad  = ($urandom_range(7) == 0) ? $urandom_range(3) : 0;
        if (kind < 75) begin
            d0   = pick_upto(base);
            left = base - d0;
            push_num(d0, pad);
            push_num(pick_upto(left), 0);
        end else if (kind < 83) begin
            if ($urandom_range(1)) begin
                push_num(base + 1 + pick_upto(~base - 1), pad);
                push_num(pick_upto('1), 0);
            end else begin
                d0   = pick_upto(base);
                left = base - d0;
                push_num(d0, pad);
                push_num(left + 1 + pick_upto(~left - 1), 0);
            end
        end else if (kind < 89) begin
            // overlong number in the first or the second delta
            if ($urandom_range(1))
                push_num(pick_upto(base), 0);
            repeat (5) add_byte({1'b1, 7'($urandom)});
        end else begin
            repeat ($urandom_range(6, 1)) add_byte(8'($urandom));
        end
    endfunction

    // pressure: 1 = long receiver stall, 2 = sender pause midway
    task automatic run_section(logic [VAR_W-1:0] fgv, logic [VAR_W-1:0] gt, int budget,
                               int pressure);
        int start;
        wait_results_drained();
        write_cfg(REG_FIRST_GATE_VAR, fgv);
        write_cfg(REG_GATE_TOTAL, gt);
        if (pressure == 1)
            rx_hold_req = 1;
        start = used_bytes;
        while (used_bytes - start < budget && sb.gates_done < sb.gate_total) begin
            if (pressure == 2 && used_bytes - start >= budget / 2) begin
                wait_results_drained();
                pressure = 0;
            end
            queue_gate();
            send_bytes();
        end
        // bytes past a finished section are dropped
        if (sb.gates_done >= sb.gate_total) begin
            add_byte(8'($urandom));
            add_byte(8'($urandom));
            send_bytes();
        end
    endtask

    initial begin : result_sink
        int hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_record(m_tdata, m_tuser, m_tlast);
            if (rx_hold_req) begin
                hold = 200;
                rx_hold_req = 0;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin : watchdog
        #2_000_000;
        $display("aiger_binary_gate_decoder_core_tb NOT OK");
        $finish;
    end

    initial begin : stimulus
        sb = new();
        tx_idle_pct = 22;
        rx_idle_pct = 46;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // after reset the gate count is zero: everything is dropped
        byte_q = '{8'h00, 8'hFF, 8'h80};
        send_bytes();

        wait_results_drained();
        write_cfg(REG_FIRST_GATE_VAR, 31'd5);
        write_cfg(REG_GATE_TOTAL, 31'd8);
        byte_q = '{8'h00, 8'h00,                           // plain gate
                   8'h0C, 8'h00,                           // first delta equals base
                   8'h0F, 8'h00,                           // first delta past base
                   8'h03, 8'h0E,                           // second delta past left
                   8'h80, 8'h80, 8'h80, 8'h80, 8'h80,      // overlong first delta
                   8'h01, 8'h81, 8'h80, 8'h80, 8'h80, 8'h80, // overlong second delta
                   8'h80, 8'h80, 8'h80, 8'h80, 8'h7F, 8'h00, // wide fifth byte
                   8'h95, 8'h00, 8'h03,                    // padded number, last gate
                   8'h00, 8'h00};                          // section done
        send_bytes();

        // largest gate variable, then wrap to variable zero
        wait_results_drained();
        write_cfg(REG_FIRST_GATE_VAR, 31'h7FFF_FFFF);
        write_cfg(REG_GATE_TOTAL, 31'd2);
        byte_q = '{8'h00, 8'hFE, 8'hFF, 8'hFF, 8'hFF, 8'h0F, 8'h01, 8'h00};
        send_bytes();

        for (int m = 0; m < 3; m++) begin
            tx_idle_pct = (m == 0) ? 22 : (m == 1) ? 46 : 0;
            rx_idle_pct = (m == 0) ? 46 : (m == 1) ? 22 : 0;
            run_section((m == 0) ? 31'd1 : 31'($urandom_range(1000, 1)), '1, 150, m + 1);
            run_section(31'h7FFF_FFFF - 31'($urandom_range(40)),
                        31'($urandom_range(30, 1)), 80, 0);
            run_section(31'($urandom) | 31'd1, 31'($urandom_range(80, 20)), 70, 0);
            run_section(31'($urandom_range(5000, 1)), 31'd1, 10, 0);
        end

        wait_results_drained();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0)
            $display("aiger_binary_gate_decoder_core_tb OK");
        else
            $display("aiger_binary_gate_decoder_core_tb NOT OK");
        $finish;
    end

endmodule
